[hdl/tbo_pkg.sv]
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared constants for the triangle versus box overlap pipeline.
// ----------------------------------------------------------------------------
package tbo_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_HALF_X   = 3'd3,
		REG_HALF_Y   = 3'd4,
		REG_HALF_Z   = 3'd5
	} cfg_reg_t;

endpackage

[hdl/tbo_prep.sv]
// ----------------------------------------------------------------------------
// tbo_prep
// Stages 1 and 2: vertices relative to the box center, then triangle edges.
// ----------------------------------------------------------------------------
module tbo_prep #(
	parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] vert [3][3],
	input  logic signed [COORD_BITS-1:0] center [3],
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS:0]   v_s2 [3][3],
	output logic signed [COORD_BITS+1:0] e_s2 [3][3]
);

	localparam int VW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 2;

	logic signed [VW-1:0] v_s1 [3][3];
	logic valid_s1, valid_s2;
	logic en_s1, en_s2;

	assign en_s2     = !valid_s2 || out_ready;
	assign en_s1     = !valid_s1 || en_s2;
	assign in_ready  = en_s1;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_vert
		localparam int NX = (i + 1) % 3;
		for (genvar k = 0; k < 3; k++) begin : g_axis
			always_ff @(posedge clk) begin
				if (en_s1) begin
					v_s1[i][k] <= VW'(vert[i][k]) - VW'(center[k]);
				end
				if (en_s2) begin
					v_s2[i][k] <= v_s1[i][k];
					e_s2[i][k] <= EW'(v_s1[NX][k]) - EW'(v_s1[i][k]);
				end
			end
		end
	end

endmodule

[hdl/tbo_proj.sv]
// ----------------------------------------------------------------------------
// tbo_proj
// Stages 3 and 4: edge-axis projections and radii, face tests, plane normal.
// ----------------------------------------------------------------------------
module tbo_proj #(
	parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [COORD_BITS:0]       v_s2 [3][3],
	input  logic signed [COORD_BITS+1:0]     e_s2 [3][3],
	input  logic        [COORD_BITS-2:0]     half [3],
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [2*COORD_BITS+3:0]   p_s4 [3][3][3],
	output logic        [2*COORD_BITS+1:0]   rad_s4 [3][3],
	output logic                             face_s4,
	output logic signed [2*COORD_BITS+4:0]   n_s4 [3],
	output logic signed [COORD_BITS+1:0]     da_s4 [3],
	output logic signed [COORD_BITS+1:0]     db_s4 [3]
);

	localparam int VW  = COORD_BITS + 1;
	localparam int EW  = COORD_BITS + 2;
	localparam int MW  = EW + VW;
	localparam int PW  = MW + 1;
	localparam int RW  = EW + COORD_BITS - 1;
	localparam int NPW = 2 * EW;
	localparam int NW  = NPW + 1;
	localparam int DW  = COORD_BITS + 2;

	logic signed [MW-1:0]  m1_s3 [3][3][3];
	logic signed [MW-1:0]  m2_s3 [3][3][3];
	logic        [RW-1:0]  r1_s3 [3][3];
	logic        [RW-1:0]  r2_s3 [3][3];
	logic signed [NPW-1:0] np1_s3 [3];
	logic signed [NPW-1:0] np2_s3 [3];
	logic signed [VW-1:0]  v0_s3 [3];
	logic                  face_s3;
	logic [EW-1:0]         emag [3][3];
	logic [2:0]            face_sep;
	logic valid_s3, valid_s4;
	logic en_s3, en_s4;

	assign en_s4     = !valid_s4 || out_ready;
	assign en_s3     = !valid_s3 || en_s4;
	assign in_ready  = en_s3;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) valid_s3 <= in_valid;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_mag
		for (genvar k = 0; k < 3; k++) begin : g_k
			assign emag[i][k] = e_s2[i][k][EW-1] ? EW'(-e_s2[i][k]) : EW'(e_s2[i][k]);
		end
	end

	// box face tests: all three vertices beyond the same face
	for (genvar k = 0; k < 3; k++) begin : g_face
		logic signed [VW-1:0] hs;
		assign hs = VW'(half[k]);
		assign face_sep[k] =
			(v_s2[0][k] > hs && v_s2[1][k] > hs && v_s2[2][k] > hs) ||
			(v_s2[0][k] < -hs && v_s2[1][k] < -hs && v_s2[2][k] < -hs);
	end

	// axis a of edge i is e x unit(a): uses components b and c of the edge
	for (genvar i = 0; i < 3; i++) begin : g_edge
		for (genvar a = 0; a < 3; a++) begin : g_ax
			localparam int B = (a + 1) % 3;
			localparam int C = (a + 2) % 3;
			always_ff @(posedge clk) begin
				if (en_s3) begin
					r1_s3[i][a] <= emag[i][C] * RW'(half[B]);
					r2_s3[i][a] <= emag[i][B] * RW'(half[C]);
				end
				if (en_s4) begin
					rad_s4[i][a] <= (RW+1)'(r1_s3[i][a]) + (RW+1)'(r2_s3[i][a]);
				end
			end
			for (genvar j = 0; j < 3; j++) begin : g_v
				always_ff @(posedge clk) begin
					if (en_s3) begin
						m1_s3[i][a][j] <= e_s2[i][C] * v_s2[j][B];
						m2_s3[i][a][j] <= e_s2[i][B] * v_s2[j][C];
					end
					if (en_s4) begin
						p_s4[i][a][j] <= PW'(m1_s3[i][a][j]) - PW'(m2_s3[i][a][j]);
					end
				end
			end
		end
	end

	// plane normal e0 x e1 and the two box corners along it
	for (genvar k = 0; k < 3; k++) begin : g_norm
		localparam int B = (k + 1) % 3;
		localparam int C = (k + 2) % 3;
		logic signed [DW-1:0] lc;
		assign lc = (np1_s3[k] > np2_s3[k]) ? -DW'(half[k]) : DW'(half[k]);
		always_ff @(posedge clk) begin
			if (en_s3) begin
				np1_s3[k] <= e_s2[0][B] * e_s2[1][C];
				np2_s3[k] <= e_s2[0][C] * e_s2[1][B];
				v0_s3[k]  <= v_s2[0][k];
			end
			if (en_s4) begin
				n_s4[k]  <= NW'(np1_s3[k]) - NW'(np2_s3[k]);
				da_s4[k] <= lc - DW'(v0_s3[k]);
				db_s4[k] <= -lc - DW'(v0_s3[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) face_s3 <= |face_sep;
		if (en_s4) face_s4 <= face_s3;
	end

endmodule

[hdl/tbo_tail.sv]
// ----------------------------------------------------------------------------
// tbo_tail
// Stages 5 and 6: separating-axis decisions, plane products and the verdict.
// ----------------------------------------------------------------------------
module tbo_tail #(
	parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [2*COORD_BITS+3:0] p_s4 [3][3][3],
	input  logic        [2*COORD_BITS+1:0] rad_s4 [3][3],
	input  logic                           face_s4,
	input  logic signed [2*COORD_BITS+4:0] n_s4 [3],
	input  logic signed [COORD_BITS+1:0]   da_s4 [3],
	input  logic signed [COORD_BITS+1:0]   db_s4 [3],
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit_s6
);

	localparam int PW = 2 * COORD_BITS + 4;
	localparam int NW = 2 * COORD_BITS + 5;
	localparam int DW = COORD_BITS + 2;
	localparam int QW = NW + DW;
	localparam int SW = QW + 2;

	logic                 sep_s5;
	logic signed [QW-1:0] qa_s5 [3];
	logic signed [QW-1:0] qb_s5 [3];
	logic [8:0]           edge_sep;
	logic signed [SW-1:0] smin, smax;
	logic valid_s5, valid_s6;
	logic en_s5, en_s6;

	assign en_s6     = !valid_s6 || out_ready;
	assign en_s5     = !valid_s5 || en_s6;
	assign in_ready  = en_s5;
	assign out_valid = valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s5) valid_s5 <= in_valid;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_edge
		for (genvar a = 0; a < 3; a++) begin : g_ax
			logic signed [PW-1:0] rs;
			assign rs = PW'(rad_s4[i][a]);
			assign edge_sep[3*i+a] =
				(p_s4[i][a][0] > rs && p_s4[i][a][1] > rs && p_s4[i][a][2] > rs) ||
				(p_s4[i][a][0] < -rs && p_s4[i][a][1] < -rs && p_s4[i][a][2] < -rs);
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_plane
		always_ff @(posedge clk) begin
			if (en_s5) begin
				qa_s5[k] <= n_s4[k] * da_s4[k];
				qb_s5[k] <= n_s4[k] * db_s4[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) sep_s5 <= face_s4 || (|edge_sep);
	end

	assign smin = SW'(qa_s5[0]) + SW'(qa_s5[1]) + SW'(qa_s5[2]);
	assign smax = SW'(qb_s5[0]) + SW'(qb_s5[1]) + SW'(qb_s5[2]);

	// plane misses the box when the near corner is above it or the far one below
	always_ff @(posedge clk) begin
		if (en_s6) hit_s6 <= !sep_s5 && (smin[SW-1] || (smin == '0)) && !smax[SW-1];
	end

endmodule

[hdl/triangle_box_overlap_test_top.sv]
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_top
// Separating-axis overlap test of a triangle against an axis-aligned box.
// ----------------------------------------------------------------------------
// One triangle request is taken per clock while the output is not stalled,
// and its overlap bit comes out of the six pipeline stages (relative
// vertices, edges, projection products, projection sums and plane normal,
// axis decisions with plane products, plane sums). Each stage stalls only
// when it holds data that cannot move on, so bubbles are squeezed out and a
// held output never blocks input while the pipe has room. Touching counts as
// overlap. The user must write box center and half extents over the config
// port only while the pipe is empty; the block does not enforce this.
module triangle_box_overlap_test_top #(
	parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tbo_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        vert0_x,
	input  logic signed [COORD_BITS-1:0]        vert0_y,
	input  logic signed [COORD_BITS-1:0]        vert0_z,
	input  logic signed [COORD_BITS-1:0]        vert1_x,
	input  logic signed [COORD_BITS-1:0]        vert1_y,
	input  logic signed [COORD_BITS-1:0]        vert1_z,
	input  logic signed [COORD_BITS-1:0]        vert2_x,
	input  logic signed [COORD_BITS-1:0]        vert2_y,
	input  logic signed [COORD_BITS-1:0]        vert2_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                overlaps
);

	import tbo_pkg::*;

	logic signed [COORD_BITS-1:0]   center_q [3];
	logic        [COORD_BITS-2:0]   half_q [3];
	logic signed [COORD_BITS-1:0]   vert [3][3];
	logic signed [COORD_BITS:0]     v_s2 [3][3];
	logic signed [COORD_BITS+1:0]   e_s2 [3][3];
	logic signed [2*COORD_BITS+3:0] p_s4 [3][3][3];
	logic        [2*COORD_BITS+1:0] rad_s4 [3][3];
	logic                           face_s4;
	logic signed [2*COORD_BITS+4:0] n_s4 [3];
	logic signed [COORD_BITS+1:0]   da_s4 [3];
	logic signed [COORD_BITS+1:0]   db_s4 [3];
	logic prep_valid, prep_ready, proj_valid, proj_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '{default: '0};
			half_q   <= '{default: '0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				REG_HALF_X:   half_q[0]   <= cfg_data[COORD_BITS-2:0];
				REG_HALF_Y:   half_q[1]   <= cfg_data[COORD_BITS-2:0];
				REG_HALF_Z:   half_q[2]   <= cfg_data[COORD_BITS-2:0];
				default: ;
			endcase
		end
	end

	assign vert[0] = '{vert0_x, vert0_y, vert0_z};
	assign vert[1] = '{vert1_x, vert1_y, vert1_z};
	assign vert[2] = '{vert2_x, vert2_y, vert2_z};

	tbo_prep #(.COORD_BITS(COORD_BITS)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.vert      (vert),
		.center    (center_q),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.v_s2      (v_s2),
		.e_s2      (e_s2)
	);

	tbo_proj #(.COORD_BITS(COORD_BITS)) u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (prep_ready),
		.v_s2      (v_s2),
		.e_s2      (e_s2),
		.half      (half_q),
		.out_valid (proj_valid),
		.out_ready (proj_ready),
		.p_s4      (p_s4),
		.rad_s4    (rad_s4),
		.face_s4   (face_s4),
		.n_s4      (n_s4),
		.da_s4     (da_s4),
		.db_s4     (db_s4)
	);

	tbo_tail #(.COORD_BITS(COORD_BITS)) u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (proj_valid),
		.in_ready  (proj_ready),
		.p_s4      (p_s4),
		.rad_s4    (rad_s4),
		.face_s4   (face_s4),
		.n_s4      (n_s4),
		.da_s4     (da_s4),
		.db_s4     (db_s4),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit_s6    (overlaps)
	);

	// an empty or draining output stage leaves the whole pipe open
	a_open_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input blocked with empty output");

	a_open_when_draining: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("input blocked while output drains");

	a_mid_request_held: assert property (@(posedge clk) disable iff (!arst_n)
		proj_valid && !proj_ready |=> proj_valid)
		else $error("request dropped between projection and tail");

	a_tail_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> proj_ready && prep_ready)
		else $error("inner stage blocked with empty output");

endmodule
